>>> hdl/lau_pkg.sv
// shared types and constants of the layer allocator with upload queue
`timescale 1ns / 1ps

package lau_pkg;

  localparam int QDEPTH       = 64;
  localparam int QIDX_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int MAX_LAYERS   = 256;
  localparam int LIDX_W       = $clog2(MAX_LAYERS);
  localparam int LCNT_W       = $clog2(MAX_LAYERS + 1);
  localparam int TILE_W       = 16;
  localparam int RESULT_LIMIT = 64;
  localparam int MAXI_W       = 7;
  localparam int HELD_W       = 9;
  localparam int ACT_W        = 2;
  localparam int STAT_W       = 2;
  localparam int LAYER_W      = 8;
  localparam int CFG_W        = 9;

  typedef enum logic [ACT_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_PROCESS = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_SHORT = 2'd2
  } status_e;

  typedef struct packed {
    logic [TILE_W-1:0]  tile;
    logic [LAYER_W-1:0] layer;
    logic               assigned;
    logic [STAT_W-1:0]  status;
    logic [QCNT_W-1:0]  pend_cnt;
    logic [LCNT_W-1:0]  free_cnt;
    logic               last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [QIDX_W-1:0] waddr;
    logic [TILE_W-1:0] wdata;
    logic              re;
    logic [QIDX_W-1:0] raddr;
  } tile_ram_req_t;

  typedef struct packed {
    logic               we;
    logic [LIDX_W-1:0]  waddr;
    logic [LAYER_W-1:0] wdata;
    logic               re;
    logic [LIDX_W-1:0]  raddr;
  } stack_ram_req_t;

endpackage

>>> hdl/lau_ram.sv
// generic single write, single read memory with registered read data
`timescale 1ns / 1ps

module lau_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lau_ctrl.sv
// sequencer for requests, cancel search, pool fill and the process loop
`timescale 1ns / 1ps

module lau_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lau_pkg::ACT_W-1:0]    action_i,
  input  logic [lau_pkg::TILE_W-1:0]   tile_id_i,
  input  logic [lau_pkg::HELD_W-1:0]   held_layer_i,
  input  logic [lau_pkg::MAXI_W-1:0]   max_items_i,
  input  logic [lau_pkg::CFG_W-1:0]    layer_count_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output lau_pkg::res_t                res_o,
  output lau_pkg::tile_ram_req_t       tile_req_o,
  input  logic [lau_pkg::TILE_W-1:0]   tile_rdata_i,
  output lau_pkg::stack_ram_req_t      stack_req_o,
  input  logic [lau_pkg::LAYER_W-1:0]  stack_rdata_i
);
  import lau_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EMIT   = 8'b0000_0010,
    S_SRD    = 8'b0000_0100,
    S_SCMP   = 8'b0000_1000,
    S_FILL   = 8'b0001_0000,
    S_PSTART = 8'b0010_0000,
    S_PCHK   = 8'b0100_0000,
    S_PUSE   = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [QCNT_W-1:0]  pend_len_q, pend_len_d;
  logic [LCNT_W-1:0]  free_len_q, free_len_d;
  logic               pool_ready_q, pool_ready_d;
  logic [QDEPTH-1:0]  valid_q, valid_d;
  logic [QIDX_W-1:0]  idx_q, idx_d;
  logic [TILE_W-1:0]  tile_q, tile_d;
  logic [MAXI_W-1:0]  max_q, max_d;
  logic [MAXI_W-1:0]  cnt_q, cnt_d;
  logic [STAT_W-1:0]  stat_q, stat_d;
  logic [LIDX_W-1:0]  fill_addr_q, fill_addr_d;
  logic [LIDX_W-1:0]  fill_val_q, fill_val_d;
  res_t               hold_q, hold_d;
  logic               hold_vld_q, hold_vld_d;

  logic [QCNT_W-1:0]  pend_dec;
  logic [LCNT_W-1:0]  free_dec;
  logic [LCNT_W-1:0]  pool_n;
  logic [LCNT_W-1:0]  pool_n_dec;
  logic [MAXI_W-1:0]  want;
  logic [QIDX_W-1:0]  pop_idx;
  logic               pop_vld;
  logic               pop_go;

  assign pend_dec   = pend_len_q - 1'b1;
  assign free_dec   = free_len_q - 1'b1;
  assign pop_idx    = pend_dec[QIDX_W-1:0];
  assign pop_vld    = valid_q[pop_idx];
  // a found assignment waits until the one before it has left
  assign pop_go     = !(pop_vld && hold_vld_q) || res_ready_i;
  assign want       = (max_q < pend_len_q) ? max_q : pend_len_q;
  assign pool_n_dec = pool_n - 1'b1;

  // pool size clamped to 1..MAX_LAYERS
  always_comb begin
    priority if (layer_count_i == '0) begin
      pool_n = LCNT_W'(1);
    end else if (LCNT_W'(layer_count_i) > LCNT_W'(MAX_LAYERS)) begin
      pool_n = LCNT_W'(MAX_LAYERS);
    end else begin
      pool_n = LCNT_W'(layer_count_i);
    end
  end

  always_comb begin
    state_d      = state_q;
    pend_len_d   = pend_len_q;
    free_len_d   = free_len_q;
    pool_ready_d = pool_ready_q;
    valid_d      = valid_q;
    idx_d        = idx_q;
    tile_d       = tile_q;
    max_d        = max_q;
    cnt_d        = cnt_q;
    stat_d       = stat_q;
    fill_addr_d  = fill_addr_q;
    fill_val_d   = fill_val_q;
    hold_d       = hold_q;
    hold_vld_d   = hold_vld_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = hold_q;
    tile_req_o   = '0;
    stack_req_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          tile_d          = tile_id_i;
          hold_d          = '0;
          hold_d.last     = 1'b1;
          hold_d.pend_cnt = pend_len_q;
          hold_d.free_cnt = free_len_q;
          state_d         = S_EMIT;
          unique case (action_e'(action_i))
            ACT_REQUEST: begin
              if (pend_len_q == QCNT_W'(QDEPTH)) begin
                hold_d.status = STATUS_FULL;
              end else begin
                tile_req_o.we          = 1'b1;
                tile_req_o.waddr       = pend_len_q[QIDX_W-1:0];
                tile_req_o.wdata       = tile_id_i;
                valid_d[pend_len_q[QIDX_W-1:0]] = 1'b1;
                pend_len_d             = pend_len_q + 1'b1;
                hold_d.pend_cnt        = pend_len_q + 1'b1;
              end
            end
            ACT_RELEASE: begin
              if (!held_layer_i[HELD_W-1]) begin
                hold_d.layer = held_layer_i[LAYER_W-1:0];
                if (free_len_q < LCNT_W'(MAX_LAYERS)) begin
                  stack_req_o.we    = 1'b1;
                  stack_req_o.waddr = free_len_q[LIDX_W-1:0];
                  stack_req_o.wdata = held_layer_i[LAYER_W-1:0];
                  free_len_d        = free_len_q + 1'b1;
                  hold_d.free_cnt   = free_len_q + 1'b1;
                end
              end else if (pend_len_q != '0) begin
                idx_d   = '0;
                state_d = S_SRD;
              end
            end
            ACT_PROCESS: begin
              if (pend_len_q != '0) begin
                max_d      = (max_items_i > MAXI_W'(RESULT_LIMIT)) ?
                             MAXI_W'(RESULT_LIMIT) : max_items_i;
                hold_vld_d = 1'b0;
                if (!pool_ready_q) begin
                  fill_addr_d  = '0;
                  fill_val_d   = pool_n_dec[LIDX_W-1:0];
                  free_len_d   = pool_n;
                  pool_ready_d = 1'b1;
                  state_d      = S_FILL;
                end else begin
                  state_d = S_PSTART;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          hold_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end

      S_SRD: begin
        tile_req_o.re    = 1'b1;
        tile_req_o.raddr = idx_q;
        state_d          = S_SCMP;
      end

      S_SCMP: begin
        if (valid_q[idx_q] && (tile_rdata_i == tile_q)) begin
          valid_d[idx_q] = 1'b0;
          state_d        = S_EMIT;
        end else if ((QCNT_W'(idx_q) + 1'b1) == pend_len_q) begin
          state_d = S_EMIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end

      S_FILL: begin
        stack_req_o.we    = 1'b1;
        stack_req_o.waddr = fill_addr_q;
        stack_req_o.wdata = fill_val_q;
        if (fill_val_q == '0) begin
          state_d = S_PSTART;
        end else begin
          fill_addr_d = fill_addr_q + 1'b1;
          fill_val_d  = fill_val_q - 1'b1;
        end
      end

      S_PSTART: begin
        stat_d  = (free_len_q < LCNT_W'(want)) ? STATUS_SHORT : STATUS_OK;
        cnt_d   = '0;
        state_d = S_PCHK;
      end

      S_PCHK: begin
        if ((pend_len_q != '0) && (cnt_q < max_q) && (free_len_q != '0)) begin
          tile_req_o.re     = 1'b1;
          tile_req_o.raddr  = pop_idx;
          stack_req_o.re    = 1'b1;
          stack_req_o.raddr = free_dec[LIDX_W-1:0];
          state_d           = S_PUSE;
        end else begin
          if (hold_vld_q) begin
            hold_d.last = 1'b1;
          end else begin
            hold_d          = '0;
            hold_d.status   = stat_q;
            hold_d.pend_cnt = pend_len_q;
            hold_d.free_cnt = free_len_q;
            hold_d.last     = 1'b1;
          end
          state_d = S_EMIT;
        end
      end

      S_PUSE: begin
        res_valid_o = pop_vld && hold_vld_q;
        if (pop_go) begin
          valid_d[pop_idx] = 1'b0;
          pend_len_d       = pend_dec;
          state_d          = S_PCHK;
          if (pop_vld) begin
            free_len_d      = free_dec;
            cnt_d           = cnt_q + 1'b1;
            hold_d.tile     = tile_rdata_i;
            hold_d.layer    = stack_rdata_i;
            hold_d.assigned = 1'b1;
            hold_d.status   = stat_q;
            hold_d.pend_cnt = pend_dec;
            hold_d.free_cnt = free_dec;
            hold_d.last     = 1'b0;
            hold_vld_d      = 1'b1;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_len_q   <= '0;
      free_len_q   <= '0;
      pool_ready_q <= 1'b0;
      valid_q      <= '0;
      hold_vld_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_len_q   <= pend_len_d;
      free_len_q   <= free_len_d;
      pool_ready_q <= pool_ready_d;
      valid_q      <= valid_d;
      hold_vld_q   <= hold_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    tile_q      <= tile_d;
    max_q       <= max_d;
    cnt_q       <= cnt_d;
    stat_q      <= stat_d;
    fill_addr_q <= fill_addr_d;
    fill_val_q  <= fill_val_d;
    hold_q      <= hold_d;
  end

endmodule

>>> hdl/layer_allocator_with_upload_queue.sv
// top level of the layer allocator with upload queue
`timescale 1ns / 1ps

// Hands out layers of a fixed pool to tiles. Action 0 appends a tile to the
// pending list, action 1 returns a held layer to the free stack or cancels
// the oldest valid pending entry of that tile, action 2 assigns layers to up
// to max_items pending tiles from the newest end, one result per assignment
// with last on the final one. The first process transfer that finds work fills
// the free stack from layer_count (clamped to 1..256), so layer 0 goes out
// first; this fill sweep writes one stack entry a cycle, and later
// layer_count writes have no effect until reset. The memory ports read or
// write one entry a cycle. A cancel scans the pending entries one by one,
// from the oldest end; a process transfer pops at most 64 pending entries,
// after the fill sweep the first time; a result that waits on a full output
// register holds the sequencer until it has left.
// in_ready_o stays low while an item is worked on.
// Results leave through an output register, so a new item can be taken while
// the last result still waits for out_ready_i. The configuration port is
// always ready and must only be written while the block is idle.

module layer_allocator_with_upload_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lau_pkg::ACT_W-1:0]          action_i,
  input  logic [lau_pkg::TILE_W-1:0]         tile_id_i,
  input  logic signed [lau_pkg::HELD_W-1:0]  held_layer_i,
  input  logic [lau_pkg::MAXI_W-1:0]         max_items_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [lau_pkg::TILE_W-1:0]         out_tile_o,
  output logic [lau_pkg::LAYER_W-1:0]        out_layer_o,
  output logic                               assigned_o,
  output logic [lau_pkg::STAT_W-1:0]         status_o,
  output logic [lau_pkg::QCNT_W-1:0]         pending_count_o,
  output logic [lau_pkg::LCNT_W-1:0]         free_count_o,
  output logic                               last_o,
  // layer_count register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lau_pkg::CFG_W-1:0]          cfg_data_i
);
  import lau_pkg::*;

  logic [CFG_W-1:0]    layer_count_q;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  tile_ram_req_t       tile_req;
  stack_ram_req_t      stack_req;
  logic [TILE_W-1:0]   tile_rdata;
  logic [LAYER_W-1:0]  stack_rdata;
  logic                out_valid_q;
  res_t                out_q;

  // configuration register, written in one transfer
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q <= CFG_W'(MAX_LAYERS);
    end else if (cfg_valid_i) begin
      layer_count_q <= cfg_data_i;
    end
  end

  lau_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .tile_id_i    (tile_id_i),
    .held_layer_i (held_layer_i),
    .max_items_i  (max_items_i),
    .layer_count_i(layer_count_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .tile_req_o   (tile_req),
    .tile_rdata_i (tile_rdata),
    .stack_req_o  (stack_req),
    .stack_rdata_i(stack_rdata)
  );

  // pending tile identities
  lau_ram #(
    .W(TILE_W),
    .D(QDEPTH)
  ) u_tile_ram (
    .clk_i  (clk_i),
    .we_i   (tile_req.we),
    .waddr_i(tile_req.waddr),
    .wdata_i(tile_req.wdata),
    .re_i   (tile_req.re),
    .raddr_i(tile_req.raddr),
    .rdata_o(tile_rdata)
  );

  // free layer stack
  lau_ram #(
    .W(LAYER_W),
    .D(MAX_LAYERS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stack_req.we),
    .waddr_i(stack_req.waddr),
    .wdata_i(stack_req.wdata),
    .re_i   (stack_req.re),
    .raddr_i(stack_req.raddr),
    .rdata_o(stack_rdata)
  );

  // output register, refilled in the cycle it empties
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_tile_o      = out_q.tile;
  assign out_layer_o     = out_q.layer;
  assign assigned_o      = out_q.assigned;
  assign status_o        = out_q.status;
  assign pending_count_o = out_q.pend_cnt;
  assign free_count_o    = out_q.free_cnt;
  assign last_o          = out_q.last;

endmodule

>>> tb/sv/layer_alloc_checker.sv
// checker for the layer allocator: predicts every result and compares it on arrival
`timescale 1ns / 1ps

module layer_alloc_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [lau_pkg::ACT_W-1:0]          action_i,
  input  logic [lau_pkg::TILE_W-1:0]         tile_id_i,
  input  logic signed [lau_pkg::HELD_W-1:0]  held_layer_i,
  input  logic [lau_pkg::MAXI_W-1:0]         max_items_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [lau_pkg::TILE_W-1:0]         out_tile_i,
  input  logic [lau_pkg::LAYER_W-1:0]        out_layer_i,
  input  logic                               assigned_i,
  input  logic [lau_pkg::STAT_W-1:0]         status_i,
  input  logic [lau_pkg::QCNT_W-1:0]         pending_count_i,
  input  logic [lau_pkg::LCNT_W-1:0]         free_count_i,
  input  logic                               last_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [lau_pkg::CFG_W-1:0]          cfg_data_i,
  output int                                 mismatches_o,
  output logic                               drained_o
);
  import lau_pkg::*;

  localparam int PRINT_CAP = 200;

  // own copy of the allocator state
  logic [TILE_W-1:0]  queued_tile [QDEPTH];
  logic               queued_live [QDEPTH];
  int                 queued_len;
  logic [LAYER_W-1:0] layer_stack [MAX_LAYERS];
  int                 stack_len;
  logic               pool_filled;
  logic [CFG_W-1:0]   layer_count;

  res_t awaited_results [$];
  int   printed;

  function automatic res_t result_of(logic [TILE_W-1:0] tile, logic [LAYER_W-1:0] layer,
                                     logic asg, status_e st);
    res_t r;
    r.tile     = tile;
    r.layer    = layer;
    r.assigned = asg;
    r.status   = st;
    r.pend_cnt = QCNT_W'(queued_len);
    r.free_cnt = LCNT_W'(stack_len);
    r.last     = 1'b0;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    mismatches_o++;
    if (printed < PRINT_CAP) begin
      printed++;
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic fill_pool();
    int n;
    n = int'(layer_count);
    if (n < 1) n = 1;
    if (n > MAX_LAYERS) n = MAX_LAYERS;
    for (int i = 0; i < n; i++) layer_stack[i] = LAYER_W'(n - 1 - i);
    stack_len   = n;
    pool_filled = 1'b1;
  endtask

  task automatic predict_alloc(input logic [ACT_W-1:0] act, input logic [TILE_W-1:0] tid,
                               input logic [HELD_W-1:0] held, input logic [MAXI_W-1:0] maxi);
    status_e st;
    res_t    r;
    logic    have;
    int      lim;
    int      want;
    int      cnt;
    st   = STATUS_OK;
    have = 1'b0;
    cnt  = 0;
    case (act)
      ACT_REQUEST: begin
        if (queued_len >= QDEPTH) begin
          st = STATUS_FULL;
        end else begin
          queued_tile[queued_len] = tid;
          queued_live[queued_len] = 1'b1;
          queued_len++;
        end
        r = result_of('0, '0, 1'b0, st);
      end
      ACT_RELEASE: begin
        if (!held[HELD_W-1]) begin
          if (stack_len < MAX_LAYERS) begin
            layer_stack[stack_len] = held[LAYER_W-1:0];
            stack_len++;
          end
          r = result_of('0, held[LAYER_W-1:0], 1'b0, STATUS_OK);
        end else begin
          // cancel the oldest live entry of this tile
          for (int i = 0; i < queued_len; i++) begin
            if (queued_live[i] && queued_tile[i] == tid) begin
              queued_live[i] = 1'b0;
              break;
            end
          end
          r = result_of('0, '0, 1'b0, STATUS_OK);
        end
      end
      ACT_PROCESS: begin
        if (queued_len == 0) begin
          r = result_of('0, '0, 1'b0, STATUS_OK);
        end else begin
          if (!pool_filled) fill_pool();
          lim  = (int'(maxi) > RESULT_LIMIT) ? RESULT_LIMIT : int'(maxi);
          want = (lim < queued_len) ? lim : queued_len;
          if (stack_len < want) st = STATUS_SHORT;
          // newest end first, cancelled entries dropped for free
          while (queued_len > 0 && cnt < lim && stack_len > 0) begin
            queued_len--;
            if (queued_live[queued_len]) begin
              queued_live[queued_len] = 1'b0;
              stack_len--;
              cnt++;
              if (have) awaited_results = {awaited_results, r};
              r    = result_of(queued_tile[queued_len], layer_stack[stack_len], 1'b1, st);
              have = 1'b1;
            end
          end
          if (!have) r = result_of('0, '0, 1'b0, st);
        end
      end
      default: r = result_of('0, '0, 1'b0, STATUS_OK);
    endcase
    r.last = 1'b1;
    awaited_results = {awaited_results, r};
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (awaited_results.size() == 0) begin
      report("result with nothing awaited, tile", got.tile, 0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.tile != want.tile) report("out_tile", got.tile, want.tile);
    if (got.layer != want.layer) report("out_layer", got.layer, want.layer);
    if (got.assigned != want.assigned) report("assigned", got.assigned, want.assigned);
    if (got.status != want.status) report("status", got.status, want.status);
    if (got.pend_cnt != want.pend_cnt) report("pending_count", got.pend_cnt, want.pend_cnt);
    if (got.free_cnt != want.free_cnt) report("free_count", got.free_cnt, want.free_cnt);
    if (got.last != want.last) report("last", got.last, want.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QDEPTH; i++) queued_live[i] = 1'b0;
      queued_len   = 0;
      stack_len    = 0;
      pool_filled  = 1'b0;
      layer_count  = CFG_W'(MAX_LAYERS);
      awaited_results.delete();
      mismatches_o = 0;
      printed      = 0;
      drained_o   <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_i) layer_count = cfg_data_i;
      // a result leaving now belongs to an earlier item, so compare before predicting
      if (out_valid_i && out_ready_i)
        check_result({out_tile_i, out_layer_i, assigned_i, status_i,
                      pending_count_i, free_count_i, last_i});
      if (in_valid_i && in_ready_i)
        predict_alloc(action_i, tile_id_i, held_layer_i, max_items_i);
      drained_o <= (awaited_results.size() == 0);
    end
  end

endmodule

>>> tb/sv/tb_layer_allocator_with_upload_queue.sv
// testbench top for the layer allocator with upload queue: stimulus and verdict
`timescale 1ns / 1ps

module tb_layer_allocator_with_upload_queue;
  import lau_pkg::*;

  // undefined action code, the block must treat it as a no-op
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int IDLE_PCT    = 17;
  localparam int RAND_ITEMS  = 310;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 40;
  // worst case: ~450 items, each with its work and its stalled results
  localparam int CYCLE_LIMIT = 800_000;
  localparam int POOL_IDS    = 12;
  localparam int RECENT      = 16;

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ACT_W-1:0]          action   = '0;
  logic [TILE_W-1:0]         tile_id  = '0;
  logic signed [HELD_W-1:0]  held     = '0;
  logic [MAXI_W-1:0]         max_items = '0;

  // result channel
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [TILE_W-1:0]         out_tile;
  logic [LAYER_W-1:0]        out_layer;
  logic                      assigned;
  logic [STAT_W-1:0]         status;
  logic [QCNT_W-1:0]         pending_count;
  logic [LCNT_W-1:0]         free_count;
  logic                      last;

  // layer_count register channel
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_data  = '0;

  int   mismatches;
  logic drained;

  // bookkeeping for stimulus shaping and the summary
  logic              quiet = 1'b0;
  int                n_items = 0;
  int                n_rand = 0;
  int                n_results = 0;
  int                n_short = 0;
  int                cycles = 0;
  logic [TILE_W-1:0] tile_pool [POOL_IDS];
  logic [TILE_W-1:0] recent [RECENT];
  int                recent_wr = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  layer_allocator_with_upload_queue uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .tile_id_i       (tile_id),
    .held_layer_i    (held),
    .max_items_i     (max_items),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_tile_o      (out_tile),
    .out_layer_o     (out_layer),
    .assigned_o      (assigned),
    .status_o        (status),
    .pending_count_o (pending_count),
    .free_count_o    (free_count),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  layer_alloc_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .tile_id_i       (tile_id),
    .held_layer_i    (held),
    .max_items_i     (max_items),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_tile_i      (out_tile),
    .out_layer_i     (out_layer),
    .assigned_i      (assigned),
    .status_i        (status),
    .pending_count_i (pending_count),
    .free_count_i    (free_count),
    .last_i          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .mismatches_o    (mismatches),
    .drained_o       (drained)
  );

  // receiver back-pressure, switched off during the quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // count result transfers; nonblocking so the stimulus reads a stable value
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (status == STATUS_SHORT) n_short <= n_short + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_layer_allocator_with_upload_queue failed");
      $finish;
    end
  end

  // one input transfer: optional random gap, then hold valid until accepted
  task automatic offer(input logic [ACT_W-1:0] act, input logic [TILE_W-1:0] tid,
                       input logic [HELD_W-1:0] hl, input logic [MAXI_W-1:0] mi);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    tile_id   <= tid;
    held      <= hl;
    max_items <= mi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  // only legal while the block is idle; valid dropped on a step of its own
  task automatic write_layer_count(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // the first edge lets the checker take in the final input transfer
  task automatic wait_drained(input int extra);
    @(posedge clk);
    while (!drained) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // mostly 1..64, with a share of zero and of values above the clamp
  function automatic logic [MAXI_W-1:0] random_max();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return MAXI_W'($urandom_range(RESULT_LIMIT + 1, (1 << MAXI_W) - 1));
    return MAXI_W'($urandom_range(1, RESULT_LIMIT));
  endfunction

  // request-heavy mix so the pool drains towards a shortage
  task automatic random_item();
    int                pick;
    logic [TILE_W-1:0] tid;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      // half from a small id set, so duplicates and cancels find matches
      tid = ($urandom_range(0, 1) == 0) ? tile_pool[$urandom_range(0, POOL_IDS - 1)]
                                        : TILE_W'($urandom);
      recent[recent_wr] = tid;
      recent_wr = (recent_wr + 1) % RECENT;
      offer(ACT_REQUEST, tid, HELD_W'($urandom), MAXI_W'($urandom));
    end else if (pick < 88) begin
      // cancel: held layer negative, tile usually one asked for lately
      tid = ($urandom_range(0, 4) != 0) ? recent[$urandom_range(0, RECENT - 1)]
                                        : TILE_W'($urandom);
      offer(ACT_RELEASE, tid, {1'b1, LAYER_W'($urandom)}, MAXI_W'($urandom));
    end else if (pick < 92) begin
      offer(ACT_RELEASE, TILE_W'($urandom), {1'b0, LAYER_W'($urandom)}, MAXI_W'($urandom));
    end else if (pick < 96) begin
      offer(ACT_UNUSED, TILE_W'($urandom), HELD_W'($urandom), MAXI_W'($urandom));
    end else begin
      offer(ACT_PROCESS, TILE_W'($urandom), HELD_W'($urandom), random_max());
    end
  endtask

  initial begin
    int burst;

    for (int i = 0; i < POOL_IDS; i++) tile_pool[i] = TILE_W'($urandom);
    for (int i = 0; i < RECENT; i++) recent[i] = tile_pool[i % POOL_IDS];

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register extremes before the pool is filled; the last one written counts
    write_layer_count('1);
    write_layer_count('0);
    write_layer_count(CFG_W'(1));
    write_layer_count(CFG_W'(MAX_LAYERS));

    // directed part
    offer(ACT_UNUSED, '1, '1, '1);                  // undefined action, no change
    offer(ACT_PROCESS, '0, '1, MAXI_W'(64));        // empty list, pool left unfilled
    offer(ACT_RELEASE, '0, HELD_W'(255), '0);       // layer released before the fill
    offer(ACT_RELEASE, '1, '0, '1);                 // layer 0 released, also forgotten
    offer(ACT_RELEASE, 16'h1234, '1, '0);           // cancel of a tile not pending
    offer(ACT_REQUEST, '1, '0, '0);
    offer(ACT_REQUEST, '0, '1, '1);
    offer(ACT_REQUEST, '1, HELD_W'(9'h0AA), MAXI_W'(7'h2A));
    offer(ACT_RELEASE, '1, HELD_W'(9'h100), '0);    // cancels the oldest of the two
    offer(ACT_PROCESS, '0, '0, '0);                 // fills the pool, assigns nothing
    offer(ACT_RELEASE, 16'h5A5A, HELD_W'(7), '0);   // free stack full, layer dropped
    offer(ACT_PROCESS, '1, '0, MAXI_W'(1));         // newest tile gets layer 0
    offer(ACT_PROCESS, '0, '0, '1);                 // clamp, cancelled entry skipped
    offer(ACT_REQUEST, 16'hABCD, '0, '0);
    offer(ACT_REQUEST, 16'h0001, '0, '0);
    offer(ACT_PROCESS, '0, '0, MAXI_W'(RESULT_LIMIT + 1));
    in_valid <= 1'b0;
    wait_drained(SETTLE);

    // pool already filled, so this write must change nothing
    write_layer_count(CFG_W'(128));

    // random rounds: a burst of mostly requests, then a process transfer;
    // long bursts overflow the pending list
    while (n_rand < RAND_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 24);
      for (int i = 0; i < burst; i++) begin
        quiet <= (n_rand >= 100 && n_rand < 180);
        random_item();
        n_rand++;
      end
      offer(ACT_PROCESS, TILE_W'($urandom), HELD_W'($urandom), random_max());
      n_rand++;
    end
    quiet    <= 1'b0;
    in_valid <= 1'b0;
    wait_drained(SETTLE);

    // extremes again, again without effect
    write_layer_count('0);
    write_layer_count('1);
    write_layer_count(CFG_W'(1));

    // short closing phase
    for (int i = 0; i < 12; i++) random_item();
    offer(ACT_PROCESS, '0, '0, MAXI_W'(RESULT_LIMIT));
    in_valid <= 1'b0;
    wait_drained(TAIL_CYCLES);

    $display("covered %0d input items (%0d random) and %0d result transfers",
             n_items, n_rand, n_results);
    $display("%0d results carried a layer shortage, %0d mismatches", n_short, mismatches);
    if (mismatches == 0) begin
      $display("tb_layer_allocator_with_upload_queue passed");
    end else begin
      $display("tb_layer_allocator_with_upload_queue failed");
    end
    $finish;
  end

endmodule

>>> layer_allocator_with_upload_queue.f
hdl/lau_pkg.sv
hdl/lau_ram.sv
hdl/lau_ctrl.sv
hdl/layer_allocator_with_upload_queue.sv
tb/sv/layer_alloc_checker.sv
tb/sv/tb_layer_allocator_with_upload_queue.sv
